>>> rtl/fspa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed slot pool allocator package
// Shared widths, codes and defaults for the slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

  // Slot index space is fixed at 256 entries by the 8-bit slot fields.
  localparam int SLOT_W      = 8;
  localparam int INDEX_SPACE = 256;
  localparam int STATUS_W    = 2;
  localparam int LIMIT_W     = 5;
  // Width used for index and count comparisons (holds up to 2 * INDEX_SPACE).
  localparam int ARITH_W     = 10;

  localparam int DEF_SLOTS_PER_BLOCK = 16;
  localparam int DEF_MAX_BLOCKS      = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

endpackage : fspa_pkg
`default_nettype wire

>>> rtl/fspa_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool allocator channels
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: one alloc or free request per item.
interface fspa_req_if;
  import fspa_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SLOT_W-1:0] slot_to_free;
  modport source (output valid, opcode, slot_to_free, input ready);
  modport sink   (input valid, opcode, slot_to_free, output ready);
endinterface : fspa_req_if

// Response channel: one result item per request.
interface fspa_rsp_if;
  import fspa_pkg::*;
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_given;
  logic [STATUS_W-1:0] status;
  modport source (output valid, slot_given, status, input ready);
  modport sink   (input valid, slot_given, status, output ready);
endinterface : fspa_rsp_if

// Configuration channel: write data for the block limit register.
interface fspa_cfg_if;
  import fspa_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : fspa_cfg_if
`default_nettype wire

>>> rtl/fixed_slot_pool_allocator_unit.sv
`default_nettype none
// A result is registered in the execute state after its request item is
// accepted, once the output register is free. Requests are accepted only when
// idle, so each item ends the freed-slot stack and in-use flag RAM reads and
// the write-back before the next is taken. Reset (synchronous, active high)
// clears stack depth, base and control state, makes one block with all slots
// fresh, sets the block limit to 16 and holds the request and configuration
// channels not ready; the RAMs are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// Fixed slot pool allocator unit
// Hands out and takes back slot indices from a pool that grows block by block.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_unit #(
  parameter int SLOTS_PER_BLOCK = fspa_pkg::DEF_SLOTS_PER_BLOCK,
  parameter int MAX_BLOCKS      = fspa_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic clk,
  input  wire logic rst,
  fspa_req_if.sink   req,
  fspa_rsp_if.source rsp,
  fspa_cfg_if.sink   cfg
);

  import fspa_pkg::*;

  localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
  localparam int FRESH_W = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int BASE_W  = SLOT_W + 1;
  localparam int DEPTH_W = SLOT_W + 1;

  localparam logic [ARITH_W-1:0] SPB_A   = ARITH_W'(SLOTS_PER_BLOCK);
  localparam logic [ARITH_W-1:0] MAXB_A  = ARITH_W'(MAX_BLOCKS);
  localparam logic [ARITH_W-1:0] SPACE_A = ARITH_W'(INDEX_SPACE);

  // Control and counter registers.
  fsm_t               state, state_next;
  logic [LIMIT_W-1:0] block_limit;
  logic [DEPTH_W-1:0] stack_depth, stack_depth_next;
  logic [BLK_W-1:0]   blocks_made, blocks_made_next;
  logic [FRESH_W-1:0] fresh_left, fresh_left_next;
  logic [BASE_W-1:0]  base, base_next;

  // Captured request and output register.
  opcode_t             op_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                out_valid;
  logic [SLOT_W-1:0]   out_slot, out_slot_next;
  status_t             out_status, out_status_next;

  // RAM ports.
  logic              req_fire;
  logic              stk_we;
  logic [SLOT_W-1:0] stk_raddr;
  logic [SLOT_W-1:0] stk_rdata;
  logic              flag_we;
  logic [SLOT_W-1:0] flag_waddr;
  logic              flag_wdata;
  logic              flag_rdata;

  // Decode helpers.
  logic               fire;
  logic [ARITH_W-1:0] slot_a;
  logic [ARITH_W-1:0] base_a;
  logic [ARITH_W-1:0] made_a;
  logic [ARITH_W-1:0] lim_a;
  logic [ARITH_W-1:0] eff_lim;
  logic               can_grow;
  logic               handed_out;
  logic               free_ok;
  logic [ARITH_W-1:0] fresh_idx;

  assign req.ready = (state == S_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = !rst;

  assign rsp.valid      = out_valid;
  assign rsp.slot_given = out_slot;
  assign rsp.status     = out_status;

  // The stack read always targets the top entry; it is used only when not empty.
  assign stk_raddr = stack_depth[SLOT_W-1:0] - SLOT_W'(1);

  // Freed-slot stack memory.
  fspa_ram #(
    .DATA_W(SLOT_W),
    .ADDR_W(SLOT_W)
  ) u_stack (
    .clk  (clk),
    .re   (req_fire),
    .raddr(stk_raddr),
    .we   (stk_we),
    .waddr(stack_depth[SLOT_W-1:0]),
    .wdata(slot_q),
    .rdata(stk_rdata)
  );

  // In-use flag memory, valid only for slots that were ever handed out.
  fspa_ram #(
    .DATA_W(1),
    .ADDR_W(SLOT_W)
  ) u_flags (
    .clk  (clk),
    .re   (req_fire),
    .raddr(req.slot_to_free),
    .we   (flag_we),
    .waddr(flag_waddr),
    .wdata(flag_wdata),
    .rdata(flag_rdata)
  );

  // Limit clamp and growth check.
  always_comb begin
    lim_a = ARITH_W'(block_limit);
    if (lim_a == '0) begin
      eff_lim = ARITH_W'(1);
    end else if (lim_a > MAXB_A) begin
      eff_lim = MAXB_A;
    end else begin
      eff_lim = lim_a;
    end
    base_a   = ARITH_W'(base);
    made_a   = base_a + SPB_A;
    can_grow = (ARITH_W'(blocks_made) < eff_lim) && ((made_a + SPB_A) <= SPACE_A);
  end

  // A slot was ever handed out if it lies in an older block, or in the
  // newest block above the fresh slots still left there.
  always_comb begin
    slot_a     = ARITH_W'(slot_q);
    handed_out = (slot_a < base_a) ||
                 ((slot_a >= base_a + ARITH_W'(fresh_left)) && (slot_a < made_a));
    free_ok    = handed_out && flag_rdata &&
                 (ARITH_W'(stack_depth) < SPACE_A);
  end

  assign fire = (state == S_EXEC) && (!out_valid || rsp.ready);

  // Next state, counter updates, RAM writes and the result.
  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    blocks_made_next = blocks_made;
    fresh_left_next  = fresh_left;
    base_next        = base;
    out_slot_next    = out_slot;
    out_status_next  = out_status;
    stk_we           = 1'b0;
    flag_we          = 1'b0;
    flag_waddr       = slot_q;
    flag_wdata       = 1'b0;
    fresh_idx        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next      = S_IDLE;
          out_slot_next   = '0;
          out_status_next = ST_OK;
          if (op_q == OP_ALLOC) begin
            priority if (stack_depth != '0) begin
              // Reuse the most recently freed slot.
              stack_depth_next = stack_depth - DEPTH_W'(1);
              out_slot_next    = stk_rdata;
              flag_we          = 1'b1;
              flag_waddr       = stk_rdata;
              flag_wdata       = 1'b1;
            end else if (fresh_left != '0) begin
              // Next fresh slot of the newest block, counting down.
              fresh_left_next = fresh_left - FRESH_W'(1);
              fresh_idx       = base_a + ARITH_W'(fresh_left_next);
              out_slot_next   = fresh_idx[SLOT_W-1:0];
              flag_we         = 1'b1;
              flag_waddr      = fresh_idx[SLOT_W-1:0];
              flag_wdata      = 1'b1;
            end else if (can_grow) begin
              // Add a block and take its highest slot.
              blocks_made_next = blocks_made + BLK_W'(1);
              base_next        = made_a[BASE_W-1:0];
              fresh_left_next  = FRESH_W'(SLOTS_PER_BLOCK - 1);
              fresh_idx        = made_a + SPB_A - ARITH_W'(1);
              out_slot_next    = fresh_idx[SLOT_W-1:0];
              flag_we          = 1'b1;
              flag_waddr       = fresh_idx[SLOT_W-1:0];
              flag_wdata       = 1'b1;
            end else begin
              out_status_next = ST_EXHAUSTED;
            end
          end else begin
            if (free_ok) begin
              // Push the slot and clear its in-use flag.
              stk_we           = 1'b1;
              stack_depth_next = stack_depth + DEPTH_W'(1);
              flag_we          = 1'b1;
              flag_waddr       = slot_q;
              flag_wdata       = 1'b0;
            end else begin
              out_status_next = ST_BAD_FREE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State machine and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_depth <= '0;
      blocks_made <= BLK_W'(1);
      fresh_left  <= FRESH_W'(SLOTS_PER_BLOCK);
      base        <= '0;
    end else begin
      state       <= state_next;
      stack_depth <= stack_depth_next;
      blocks_made <= blocks_made_next;
      fresh_left  <= fresh_left_next;
      base        <= base_next;
    end
  end

  // Block limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      block_limit <= cfg.data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q   <= opcode_t'(req.opcode);
      slot_q <= req.slot_to_free;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_slot   <= out_slot_next;
    out_status <= out_status_next;
  end

endmodule : fixed_slot_pool_allocator_unit
`default_nettype wire

>>> rtl/fspa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fspa_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : fspa_ram
`default_nettype wire
